/* src/bank_switch_mapper_with_scanline_irq_macros.svh */
// Assertion macros shared by the mapper modules.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsm: same-cycle check failed");
// Next-cycle implication.
`define BSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsm: next-cycle check failed");
`else
`define BSM_ASSERT_NOW(label, clk, rst, ante, cons)
`define BSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/bsm_pkg.sv */
// Types, codes and constants for the bank mapper.
package bsm_pkg;

   // Item kinds.
   localparam logic [1:0] OP_REG_WRITE  = 2'd0;
   localparam logic [1:0] OP_SRAM_WRITE = 2'd1;
   localparam logic [1:0] OP_SCANLINE   = 2'd2;

   // Register decode: only address bits 15..13 and 0 take part.
   localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
   localparam logic [15:0] REG_BANK_SELECT  = 16'h8000;
   localparam logic [15:0] REG_BANK_DATA    = 16'h8001;
   localparam logic [15:0] REG_MIRRORING    = 16'hA000;
   localparam logic [15:0] REG_IRQ_LOAD_OFF = 16'hC000;
   localparam logic [15:0] REG_IRQ_LOAD_ON  = 16'hC001;
   localparam logic [15:0] REG_IRQ_DISABLE  = 16'hE000;
   localparam logic [15:0] REG_IRQ_ENABLE   = 16'hE001;

   // Select targets chosen by bank_select bits 2..0.
   localparam logic [2:0] SEL_CHR_PAIR0 = 3'd0;
   localparam logic [2:0] SEL_CHR_PAIR1 = 3'd1;
   localparam logic [2:0] SEL_CHR_1K0   = 3'd2;
   localparam logic [2:0] SEL_CHR_1K1   = 3'd3;
   localparam logic [2:0] SEL_CHR_1K2   = 3'd4;
   localparam logic [2:0] SEL_CHR_1K3   = 3'd5;
   localparam logic [2:0] SEL_PRG0      = 3'd6;
   localparam logic [2:0] SEL_PRG1      = 3'd7;

   localparam int PRG_SWAP_BIT = 6;
   localparam int CHR_SWAP_BIT = 7;

   localparam logic [7:0] CHR_PAIR_MASK    = 8'hFE;
   localparam logic [7:0] IRQ_RELOAD_VALUE = 8'hBE;
   localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

   // Mirroring codes.
   localparam logic [1:0] MIR_VERTICAL    = 2'd0;
   localparam logic [1:0] MIR_HORIZONTAL  = 2'd1;
   localparam logic [1:0] MIR_FOUR_SCREEN = 2'd2;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 9;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROM_BANK_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOUR_SCREEN    = 1'b1;
   localparam logic [8:0] ROM_BANK_COUNT_RESET = 9'd32;

   typedef struct packed {
      logic [8:0] rom_bank_count;
      logic       four_screen;
   } bsm_cfg_type;

   typedef struct packed {
      logic [7:0]      bank_select;
      logic [1:0][7:0] prg_select;
      logic [5:0][7:0] chr_select;
      logic            override_active;
      logic [7:0]      override_bank;
      logic            mirror_horizontal;
      logic            irq_enable;
      logic [7:0]      irq_count;
      logic [7:0]      irq_reload;
   } bsm_state_type;

   localparam bsm_state_type STATE_RESET = '{
      bank_select:       8'd0,
      prg_select:        {8'd1, 8'd0},
      chr_select:        {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0},
      override_active:   1'b0,
      override_bank:     8'd0,
      mirror_horizontal: 1'b0,
      irq_enable:        1'b0,
      irq_count:         8'd0,
      irq_reload:        8'd0
   };

   typedef struct packed {
      logic [31:0] program_banks;
      logic [63:0] character_banks;
      logic [1:0]  mirroring;
      logic        irq_pulse;
   } bsm_result_type;

endpackage

/* src/bank_switch_mapper_with_scanline_irq.sv */
// Top level of the bank mapper with scanline interrupt counter.
//
//   port group  direction  handshake            contents
//   req_*       in         req_valid/req_ready  register write, save-RAM write or line tick
//   rsp_*       out        rsp_valid/rsp_ready  bank maps, mirroring and IRQ pulse
//   csr_*       in         csr_write_en         rom_bank_count (0), four_screen (1)
//
// One item is accepted per cycle while req_ready is high; its result beat is registered.
// The state update and the bank layout are one combinational pass into the result buffer.
// A skid register lets input continue for one beat after rsp_ready drops; req_ready falls
// only when both result registers are full.
// Synchronous reset restores the power-on bank layout and a count of 32 program banks.
module bank_switch_mapper_with_scanline_irq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [15:0]                          req_address,
   input  logic [7:0]                           req_data,
   input  logic [8:0]                           req_scanline,
   input  logic                                 req_rendering_on,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [31:0]                          rsp_program_banks,
   output logic [63:0]                          rsp_character_banks,
   output logic [1:0]                           rsp_mirroring,
   output logic                                 rsp_irq_pulse,
   input  logic                                 csr_write_en,
   input  logic [bsm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bsm_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import bsm_pkg::*;

   logic           accept;
   logic           irq_fire;
   bsm_state_type  state_next;
   bsm_cfg_type    cfg;
   bsm_result_type result;
   bsm_result_type rsp_data;

   assign accept = req_valid && req_ready;

   bsm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .address      (req_address),
      .data         (req_data),
      .scanline     (req_scanline),
      .rendering_on (req_rendering_on),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .state_next   (state_next),
      .cfg          (cfg),
      .irq_fire     (irq_fire)
   );

   bsm_layout u_layout (
      .state    (state_next),
      .cfg      (cfg),
      .irq_fire (irq_fire),
      .result   (result)
   );

   bsm_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   assign rsp_program_banks   = rsp_data.program_banks;
   assign rsp_character_banks = rsp_data.character_banks;
   assign rsp_mirroring       = rsp_data.mirroring;
   assign rsp_irq_pulse       = rsp_data.irq_pulse;

endmodule

/* src/bsm_regs.sv */
// Mapper register file, configuration registers and scanline IRQ counter.
`include "bank_switch_mapper_with_scanline_irq_macros.svh"

module bsm_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [1:0]                           operation,
   input  logic [15:0]                          address,
   input  logic [7:0]                           data,
   input  logic [8:0]                           scanline,
   input  logic                                 rendering_on,
   input  logic                                 csr_write_en,
   input  logic [bsm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bsm_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output bsm_pkg::bsm_state_type               state_next,
   output bsm_pkg::bsm_cfg_type                 cfg,
   output logic                                 irq_fire
);
   import bsm_pkg::*;

   bsm_state_type state_ff, state_in;
   bsm_cfg_type   cfg_ff, cfg_in;
   logic          irq_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_ROM_BANK_COUNT: cfg_in.rom_bank_count = csr_data[8:0];
            CSR_FOUR_SCREEN:    cfg_in.four_screen = csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      irq_fire = 1'b0;
      irq_load = 1'b0;
      if (accept) begin
         case (operation)
            OP_REG_WRITE: begin
               case (address & ADDR_DECODE_MASK)
                  REG_BANK_SELECT: begin
                     state_in.bank_select = data;
                     state_in.override_active = 1'b0;
                  end
                  REG_BANK_DATA: begin
                     case (state_ff.bank_select[2:0])
                        SEL_CHR_PAIR0: state_in.chr_select[0] = data & CHR_PAIR_MASK;
                        SEL_CHR_PAIR1: state_in.chr_select[1] = data & CHR_PAIR_MASK;
                        SEL_CHR_1K0:   state_in.chr_select[2] = data;
                        SEL_CHR_1K1:   state_in.chr_select[3] = data;
                        SEL_CHR_1K2:   state_in.chr_select[4] = data;
                        SEL_CHR_1K3:   state_in.chr_select[5] = data;
                        SEL_PRG0: begin
                           state_in.prg_select[0] = data;
                           state_in.override_active = 1'b0;
                        end
                        SEL_PRG1: begin
                           state_in.prg_select[1] = data;
                           state_in.override_active = 1'b0;
                        end
                        default: ;
                     endcase
                  end
                  REG_MIRRORING: begin
                     if (!cfg_ff.four_screen) begin
                        state_in.mirror_horizontal = data[0];
                     end
                  end
                  REG_IRQ_LOAD_OFF: begin
                     irq_load = 1'b1;
                     state_in.irq_count = IRQ_RELOAD_VALUE;
                     state_in.irq_reload = IRQ_RELOAD_VALUE;
                     state_in.irq_enable = 1'b0;
                  end
                  REG_IRQ_LOAD_ON: begin
                     irq_load = 1'b1;
                     state_in.irq_count = IRQ_RELOAD_VALUE;
                     state_in.irq_reload = IRQ_RELOAD_VALUE;
                     state_in.irq_enable = 1'b1;
                  end
                  REG_IRQ_DISABLE: state_in.irq_enable = 1'b0;
                  REG_IRQ_ENABLE:  state_in.irq_enable = 1'b1;
                  default: ;
               endcase
            end
            OP_SRAM_WRITE: begin
               state_in.override_active = 1'b1;
               state_in.override_bank = data;
            end
            OP_SCANLINE: begin
               // The counter only moves on visible lines while rendering.
               if (state_ff.irq_enable && (scanline <= LAST_VISIBLE_LINE) && rendering_on) begin
                  if (state_ff.irq_count == 8'd0) begin
                     state_in.irq_count = state_ff.irq_reload;
                     irq_fire = 1'b1;
                  end else begin
                     state_in.irq_count = state_ff.irq_count - 8'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         cfg_ff <= '{rom_bank_count: ROM_BANK_COUNT_RESET, four_screen: 1'b0};
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
      end
   end

   assign state_next = state_in;
   assign cfg = cfg_ff;

   `BSM_ASSERT_NOW(a_fire_only_on_tick, clock, reset, irq_fire, accept && (operation == OP_SCANLINE))
   `BSM_ASSERT_NEXT(a_sram_sets_override, clock, reset, accept && (operation == OP_SRAM_WRITE), state_ff.override_active)
   `BSM_ASSERT_NEXT(a_irq_load_value, clock, reset, irq_load, (state_ff.irq_count == IRQ_RELOAD_VALUE) && (state_ff.irq_reload == IRQ_RELOAD_VALUE))

endmodule

/* src/bsm_layout.sv */
// Builds the program and character bank maps and mirroring from the mapper state.
module bsm_layout (
   input  bsm_pkg::bsm_state_type  state,
   input  bsm_pkg::bsm_cfg_type    cfg,
   input  logic                    irq_fire,
   output bsm_pkg::bsm_result_type result
);
   import bsm_pkg::*;

   logic [7:0]  last_minus2;
   logic [7:0]  last_minus1;
   logic [31:0] chr_pairs;
   logic [31:0] chr_singles;

   assign last_minus2 = cfg.rom_bank_count[7:0] - 8'd2;
   assign last_minus1 = cfg.rom_bank_count[7:0] - 8'd1;

   assign chr_pairs = {state.chr_select[1] + 8'd1, state.chr_select[1],
                       state.chr_select[0] + 8'd1, state.chr_select[0]};
   assign chr_singles = {state.chr_select[5], state.chr_select[4],
                         state.chr_select[3], state.chr_select[2]};

   always_comb begin
      // The save-RAM override maps a 16 KB pair; the doubling wraps to 8 bits.
      if (state.override_active) begin
         result.program_banks = {last_minus1, last_minus2,
                                 state.override_bank[6:0], 1'b1,
                                 state.override_bank[6:0], 1'b0};
      end else if (state.bank_select[PRG_SWAP_BIT]) begin
         result.program_banks = {last_minus1, state.prg_select[0],
                                 state.prg_select[1], last_minus2};
      end else begin
         result.program_banks = {last_minus1, last_minus2,
                                 state.prg_select[1], state.prg_select[0]};
      end

      if (state.bank_select[CHR_SWAP_BIT]) begin
         result.character_banks = {chr_pairs, chr_singles};
      end else begin
         result.character_banks = {chr_singles, chr_pairs};
      end

      if (cfg.four_screen) begin
         result.mirroring = MIR_FOUR_SCREEN;
      end else if (state.mirror_horizontal) begin
         result.mirroring = MIR_HORIZONTAL;
      end else begin
         result.mirroring = MIR_VERTICAL;
      end

      result.irq_pulse = irq_fire;
   end

endmodule

/* src/bsm_out_buf.sv */
// Two-entry result buffer: an output register with a skid register behind it.
`include "bank_switch_mapper_with_scanline_irq_macros.svh"

module bsm_out_buf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bsm_pkg::bsm_result_type push_data,
   output logic                    push_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bsm_pkg::bsm_result_type out_data
);
   import bsm_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   bsm_result_type out_data_ff, out_data_in;
   bsm_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign pop = out_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in = out_data_ff;
      skid_data_in = skid_data_ff;
      if (pop || !out_valid_ff) begin
         // The output slot frees up: the oldest waiting beat moves forward.
         if (skid_valid_ff) begin
            out_data_in = skid_data_ff;
            out_valid_in = 1'b1;
            skid_valid_in = push;
            skid_data_in = push_data;
         end else begin
            out_data_in = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_data_in = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

   `BSM_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

endmodule

/* verif/bank_map_checker.sv */
// Bank map predictor and result comparator for the mapper testbench.
module bank_map_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic [15:0]                         req_address,
   input  logic [7:0]                          req_data,
   input  logic [8:0]                          req_scanline,
   input  logic                                req_rendering_on,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [31:0]                         rsp_program_banks,
   input  logic [63:0]                         rsp_character_banks,
   input  logic [1:0]                          rsp_mirroring,
   input  logic                                rsp_irq_pulse,
   input  logic                                csr_write_en,
   input  logic [bsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  maps_outstanding,
   output int                                  irq_pulses_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import bsm_pkg::*;

   // Shadow copy of the mapper registers and the configuration.
   logic [7:0] select_reg;
   logic [7:0] prg_bank_sel [2];
   logic [7:0] chr_bank_sel [6];
   logic       sram_override;
   logic [7:0] sram_override_bank;
   logic       mirror_h;
   logic       irq_armed;
   logic [7:0] line_count_shadow;
   logic [7:0] line_reload_shadow;
   logic [8:0] prg_rom_banks;
   logic       four_screen_cart;

   bsm_result_type expected_maps[$];
   int error_total;
   int pulse_total;

   task automatic clear_mapper();
      select_reg         = 8'd0;
      prg_bank_sel[0]    = 8'd0;
      prg_bank_sel[1]    = 8'd1;
      chr_bank_sel[0]    = 8'd0;
      chr_bank_sel[1]    = 8'd2;
      chr_bank_sel[2]    = 8'd4;
      chr_bank_sel[3]    = 8'd5;
      chr_bank_sel[4]    = 8'd6;
      chr_bank_sel[5]    = 8'd7;
      sram_override      = 1'b0;
      sram_override_bank = 8'd0;
      mirror_h           = 1'b0;
      irq_armed          = 1'b0;
      line_count_shadow  = 8'd0;
      line_reload_shadow = 8'd0;
      prg_rom_banks      = ROM_BANK_COUNT_RESET;
      four_screen_cart   = 1'b0;
   endtask

   // Applies one beat to the shadow registers and builds the bank map it reports.
   task automatic apply_mapper_beat(input logic [1:0] op, input logic [15:0] addr,
                                    input logic [7:0] data, input logic [8:0] line,
                                    input logic rendering, output bsm_result_type map);
      logic [2:0]  target;
      logic [7:0]  fixed_lo;
      logic [7:0]  fixed_hi;
      logic [7:0]  pair_base;
      logic [31:0] pairs;
      logic [31:0] singles;
      map.irq_pulse = 1'b0;
      case (op)
         OP_REG_WRITE: begin
            case (addr & ADDR_DECODE_MASK)
               REG_BANK_SELECT: begin
                  select_reg    = data;
                  sram_override = 1'b0;
               end
               REG_BANK_DATA: begin
                  target = select_reg[2:0];
                  if (target == SEL_CHR_PAIR0 || target == SEL_CHR_PAIR1) begin
                     chr_bank_sel[target] = data & CHR_PAIR_MASK;
                  end else if (target == SEL_PRG0 || target == SEL_PRG1) begin
                     prg_bank_sel[target == SEL_PRG1] = data;
                     sram_override = 1'b0;
                  end else begin
                     chr_bank_sel[target] = data;
                  end
               end
               REG_MIRRORING: begin
                  if (!four_screen_cart) mirror_h = data[0];
               end
               REG_IRQ_LOAD_OFF, REG_IRQ_LOAD_ON: begin
                  line_count_shadow  = IRQ_RELOAD_VALUE;
                  line_reload_shadow = IRQ_RELOAD_VALUE;
                  irq_armed   = ((addr & ADDR_DECODE_MASK) == REG_IRQ_LOAD_ON);
               end
               REG_IRQ_DISABLE: irq_armed = 1'b0;
               REG_IRQ_ENABLE:  irq_armed = 1'b1;
               default: ;
            endcase
         end
         OP_SRAM_WRITE: begin
            sram_override      = 1'b1;
            sram_override_bank = data;
         end
         OP_SCANLINE: begin
            if (irq_armed && line <= LAST_VISIBLE_LINE && rendering) begin
               if (line_count_shadow == 8'd0) begin
                  line_count_shadow = line_reload_shadow;
                  map.irq_pulse     = 1'b1;
               end else begin
                  line_count_shadow = line_count_shadow - 8'd1;
               end
            end
         end
         default: ;
      endcase

      // The fixed banks wrap modulo 256, so only the low byte of the count matters.
      fixed_lo = prg_rom_banks[7:0] - 8'd2;
      fixed_hi = prg_rom_banks[7:0] - 8'd1;
      if (sram_override) begin
         pair_base = {sram_override_bank[6:0], 1'b0};
         map.program_banks = {fixed_hi, fixed_lo, pair_base | 8'd1, pair_base};
      end else if (select_reg[PRG_SWAP_BIT]) begin
         map.program_banks = {fixed_hi, prg_bank_sel[0], prg_bank_sel[1], fixed_lo};
      end else begin
         map.program_banks = {fixed_hi, fixed_lo, prg_bank_sel[1], prg_bank_sel[0]};
      end
      pairs   = {chr_bank_sel[1] + 8'd1, chr_bank_sel[1], chr_bank_sel[0] + 8'd1, chr_bank_sel[0]};
      singles = {chr_bank_sel[5], chr_bank_sel[4], chr_bank_sel[3], chr_bank_sel[2]};
      map.character_banks = select_reg[CHR_SWAP_BIT] ? {pairs, singles} : {singles, pairs};
      map.mirroring = four_screen_cart ? MIR_FOUR_SCREEN :
                      (mirror_h ? MIR_HORIZONTAL : MIR_VERTICAL);
   endtask

   always @(posedge clock) begin : watch
      bsm_result_type want;
      bsm_result_type fresh;
      if (reset) begin
         clear_mapper();
         expected_maps.delete();
         error_total = 0;
         pulse_total = 0;
      end else begin
         // A result beat can never belong to the request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_maps.size() == 0) begin
               $error("result beat arrived with no request pending");
               error_total++;
            end else begin
               want = expected_maps.pop_front();
               if (rsp_irq_pulse === 1'b1) pulse_total++;
               if (rsp_program_banks !== want.program_banks) begin
                  $error("program_banks: expected %h, got %h",
                         want.program_banks, rsp_program_banks);
                  error_total++;
               end
               if (rsp_character_banks !== want.character_banks) begin
                  $error("character_banks: expected %h, got %h",
                         want.character_banks, rsp_character_banks);
                  error_total++;
               end
               if (rsp_mirroring !== want.mirroring) begin
                  $error("mirroring: expected %0d, got %0d", want.mirroring, rsp_mirroring);
                  error_total++;
               end
               if (rsp_irq_pulse !== want.irq_pulse) begin
                  $error("irq_pulse: expected %0d, got %0d", want.irq_pulse, rsp_irq_pulse);
                  error_total++;
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_ROM_BANK_COUNT) prg_rom_banks = csr_data;
            else if (csr_index == CSR_FOUR_SCREEN) four_screen_cart = csr_data[0];
         end
         if (req_valid && req_ready) begin
            apply_mapper_beat(req_operation, req_address, req_data, req_scanline,
                              req_rendering_on, fresh);
            expected_maps.push_back(fresh);
         end
      end
      mismatch_count   <= error_total;
      maps_outstanding <= expected_maps.size();
      irq_pulses_seen  <= pulse_total;
   end

endmodule

/* verif/tb_bank_switch_mapper_with_scanline_irq.sv */
// Stimulus, configuration phases and verdict for the bank mapper testbench.
module tb_bank_switch_mapper_with_scanline_irq;
   timeunit 1ns;
   timeprecision 1ps;
   import bsm_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 140;
   localparam int CHUNK_ITEMS = 35;
   localparam int LONG_HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_operation;
   logic [15:0] req_address;
   logic [7:0]  req_data;
   logic [8:0]  req_scanline;
   logic        req_rendering_on;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_program_banks;
   logic [63:0] rsp_character_banks;
   logic [1:0]  rsp_mirroring;
   logic        rsp_irq_pulse;
   logic        csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int  mismatch_count;
   int  maps_outstanding;
   int  irq_pulses_seen;
   int  cycle_count;
   int  items_sent;
   int  raster_line;
   logic sender_steady;
   logic receiver_steady;
   logic hold_results;

   bank_switch_mapper_with_scanline_irq dut (.*);

   bank_map_checker map_check (.*);

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one beat and returns just after the edge that accepts it.
   task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data, input logic [8:0] line,
                            input logic rendering);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_operation    = op;
      req_address      = addr;
      req_data         = data;
      req_scanline     = line;
      req_rendering_on = rendering;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Withdraws the offer first so the last beat is not taken again.
   task automatic wait_all_results();
      @(negedge clock);
      req_valid = 1'b0;
      do @(posedge clock); while (maps_outstanding != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = index;
      csr_data     = value;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic send_random_item();
      int roll;
      int pick;
      logic [15:0] addr;
      logic [8:0]  line;
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
         // Mostly a running raster so the counter sees whole frames.
         if ($urandom_range(0, 99) < 85) begin
            line = 9'(raster_line);
            raster_line = (raster_line == 261) ? 0 : raster_line + 1;
         end else begin
            line = 9'($urandom_range(0, 511));
         end
         send_item(OP_SCANLINE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   line, $urandom_range(0, 99) < 90);
      end else if (roll < 90) begin
         pick = $urandom_range(0, 199);
         if (pick < 60)       addr = REG_BANK_SELECT;
         else if (pick < 130) addr = REG_BANK_DATA;
         else if (pick < 150) addr = REG_MIRRORING;
         else if (pick < 170) addr = REG_IRQ_ENABLE;
         else if (pick < 176) addr = REG_IRQ_DISABLE;
         else if (pick < 178) addr = REG_IRQ_LOAD_ON;
         else if (pick < 179) addr = REG_IRQ_LOAD_OFF;
         else if (pick[0])    addr = REG_MIRRORING | 16'h0001;
         else                 addr = 16'h0000;
         if (pick < 179 || pick[0]) begin
            addr = addr | (16'($urandom_range(0, 65535)) & ~ADDR_DECODE_MASK);
         end else begin
            addr = {1'b0, 15'($urandom_range(0, 32767))};
         end
         send_item(OP_REG_WRITE, addr, 8'($urandom_range(0, 255)),
                   9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
      end else if (roll < 97) begin
         send_item(OP_SRAM_WRITE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
      end else begin
         send_item(OP_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                   9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
      end
   endtask

   // Result side: random back-pressure, quiet stretches and one long hold-off.
   initial begin : result_sink
      int roll;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            hold_results = 1'b0;
         end else if (receiver_steady || reset) begin
            rsp_ready = 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               rsp_ready = 1'b0;
               repeat ($urandom_range(8, 40) - 1) @(negedge clock);
            end else begin
               rsp_ready = (roll >= 25);
            end
         end
      end
   end

   initial begin : stimulus
      logic [8:0] bank_counts [PHASES];
      logic       four_flags  [PHASES];
      req_valid        = 1'b0;
      req_operation    = OP_REG_WRITE;
      req_address      = 16'h0000;
      req_data         = 8'h00;
      req_scanline     = 9'd0;
      req_rendering_on = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = CSR_ROM_BANK_COUNT;
      csr_data         = '0;
      reset            = 1'b1;
      cycle_count      = 0;
      items_sent       = 0;
      raster_line      = 0;
      sender_steady    = 1'b0;
      receiver_steady  = 1'b0;
      hold_results     = 1'b0;
      bank_counts = '{9'd256, 9'd2, 9'd0, 9'd1, 9'd511, 9'd255, 9'd32, 9'd0};
      four_flags  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
      bank_counts[PHASES-1] = 9'($urandom_range(0, 511));
      four_flags[PHASES-1]  = 1'($urandom_range(0, 1));
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed beats under the power-on configuration.
      send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 9'd511, 1'b1);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_item(OP_REG_WRITE, 16'h0000, 8'hFF, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_MIRRORING | 16'h0001, 8'hFF, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, {5'd0, SEL_CHR_PAIR0}, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_DATA, 8'hFF, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, {5'd0, SEL_CHR_PAIR1}, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_DATA, 8'h01, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, {5'd0, SEL_CHR_1K0}, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_DATA, 8'hFF, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, {5'd0, SEL_PRG0}, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_DATA, 8'hFF, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, {2'b11, 3'd0, SEL_PRG1}, 9'd0, 1'b0);
      send_item(OP_SRAM_WRITE, 16'h1234, 8'hFF, 9'd0, 1'b0);
      // A program select write drops the save-RAM override again.
      send_item(OP_REG_WRITE, REG_BANK_DATA | 16'h1FFE, 8'h80, 9'd0, 1'b0);
      send_item(OP_SRAM_WRITE, 16'hFFFF, 8'h00, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_BANK_SELECT, 8'h00, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_MIRRORING, 8'h01, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_IRQ_LOAD_ON, 8'h00, 9'd0, 1'b0);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, LAST_VISIBLE_LINE, 1'b1);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, 9'd240, 1'b1);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, 9'd100, 1'b0);
      send_item(OP_REG_WRITE, REG_IRQ_DISABLE, 8'h00, 9'd0, 1'b0);
      send_item(OP_SCANLINE, 16'h0000, 8'h00, 9'd5, 1'b1);
      send_item(OP_REG_WRITE, REG_IRQ_ENABLE, 8'h00, 9'd0, 1'b0);
      send_item(OP_REG_WRITE, REG_IRQ_LOAD_OFF, 8'h00, 9'd0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         // The mapper must be idle before its configuration changes.
         wait_all_results();
         write_csr(CSR_ROM_BANK_COUNT, bank_counts[phase]);
         write_csr(CSR_FOUR_SCREEN, {8'd0, four_flags[phase]});
         for (int chunk = 0; chunk < PHASE_ITEMS / CHUNK_ITEMS; chunk++) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            if (phase == 1 && chunk == 0) begin
               // Keep offering beats while the result side is held off.
               sender_steady = 1'b1;
               hold_results  = 1'b1;
            end
            for (int n = 0; n < CHUNK_ITEMS; n++) send_random_item();
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      wait_all_results();
      repeat (4) @(posedge clock);
      if (maps_outstanding != 0) $error("%0d result beats never arrived", maps_outstanding);
      $display("Drove %0d mapper beats across %0d configuration settings.",
               items_sent, PHASES + 1);
      $display("Saw %0d interrupt pulses and %0d field mismatches.",
               irq_pulses_seen, mismatch_count);
      if (mismatch_count == 0 && maps_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
